// ===== rtl/core/channel_mode_controller_assert.svh =====
// Assertion macros for the channel mode controller
`ifndef CHANNEL_MODE_CONTROLLER_ASSERT_SVH
`define CHANNEL_MODE_CONTROLLER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define CMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/cmc_pkg.sv =====
// Package: types, constants and detail table of the channel mode controller
`timescale 1ns / 1ps
`default_nettype none
package cmc_pkg;
  localparam int unsigned ChannelsDefault = 10;
  localparam logic [15:0] LongPressReset = 16'd4000;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    SRC_WARN  = 2'd0,
    SRC_FAULT = 2'd1,
    SRC_VOLT  = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    REG_LONG  = 2'd0,
    REG_LOW   = 2'd1,
    REG_MID   = 2'd2,
    REG_HIGH  = 2'd3
  } reg_e;

  localparam logic [3:0] LED_BLUE         = 4'd0;
  localparam logic [3:0] LED_GREEN        = 4'd1;
  localparam logic [3:0] LED_GREEN_PAT    = 4'd2;
  localparam logic [3:0] LED_BLUE_PAT     = 4'd3;
  localparam logic [3:0] LED_RED          = 4'd4;
  localparam logic [3:0] LED_YELLOW       = 4'd5;
  localparam logic [3:0] LED_RED_YELLOW   = 4'd6;
  localparam logic [3:0] LED_YELLOW_BLINK = 4'd7;
  localparam logic [3:0] LED_RED_BLINK    = 4'd8;
  localparam logic [3:0] LED_KEEP         = 4'd9;

  localparam logic [4:0] M_OFF = 5'd0;
  localparam logic [4:0] M_READY = 5'd1;
  localparam logic [4:0] M_MON = 5'd2;
  localparam logic [4:0] M_SEL_LOW = 5'd3;
  localparam logic [4:0] M_SEL_MID = 5'd4;
  localparam logic [4:0] M_SEL_HIGH = 5'd5;
  localparam logic [4:0] M_WARN = 5'd6;
  localparam logic [4:0] M_FAULT = 5'd7;
  localparam logic [4:0] M_VOLT = 5'd8;
  localparam logic [4:0] M_WARN_DET = 5'd9;
  localparam logic [4:0] M_FAULT_DET = 5'd13;
  localparam logic [4:0] M_VOLT_DET = 5'd21;
  localparam logic [4:0] M_LAST_DET = 5'd22;

  typedef struct packed {
    logic [3:0] channel;
    logic       key_pressed;
    logic [3:0] fault_ok;
    logic [3:0] warn_ok;
    logic [1:0] volt_ok;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_channel;
    logic [4:0]  mode;
    logic [3:0]  detail_code;
    logic [3:0]  led_code;
    logic        setpoint_write;
    logic [15:0] setpoint_word;
    logic [15:0] setpoint_shifted;
    logic        ack_open_circuit;
    logic        ack_alarms;
  } out_item_t;

  typedef struct packed {
    logic [4:0] on_short;
    logic [4:0] on_long;
    logic [3:0] detail;
    logic [3:0] led;
    src_e       src;
    logic [1:0] bit_sel;
    logic [4:0] all_next;
    logic [4:0] flag_next;
  } detail_row_t;

  function automatic detail_row_t detail_row(input logic [3:0] idx);
    detail_row_t r;
    case (idx)
      4'd0:  r = '{5'd10, 5'd6, 4'd1, LED_YELLOW_BLINK, SRC_WARN, 2'd0, 5'd6, 5'd10};
      4'd1:  r = '{5'd11, 5'd6, 4'd2, LED_YELLOW_BLINK, SRC_WARN, 2'd1, 5'd6, 5'd11};
      4'd2:  r = '{5'd12, 5'd6, 4'd3, LED_YELLOW_BLINK, SRC_WARN, 2'd2, 5'd6, 5'd12};
      4'd3:  r = '{5'd9,  5'd6, 4'd4, LED_YELLOW_BLINK, SRC_WARN, 2'd3, 5'd6, 5'd9};
      4'd4:  r = '{5'd14, 5'd7, 4'd5, LED_RED_BLINK, SRC_FAULT, 2'd0, 5'd7, 5'd14};
      4'd5:  r = '{5'd15, 5'd7, 4'd6, LED_RED_BLINK, SRC_FAULT, 2'd1, 5'd7, 5'd15};
      4'd6:  r = '{5'd16, 5'd7, 4'd7, LED_RED_BLINK, SRC_FAULT, 2'd2, 5'd7, 5'd16};
      4'd7:  r = '{5'd17, 5'd7, 4'd8, LED_RED_BLINK, SRC_FAULT, 2'd3, 5'd7, 5'd17};
      4'd8:  r = '{5'd18, 5'd7, 4'd1, LED_YELLOW_BLINK, SRC_WARN, 2'd0, 5'd13, 5'd18};
      4'd9:  r = '{5'd19, 5'd7, 4'd2, LED_YELLOW_BLINK, SRC_WARN, 2'd1, 5'd13, 5'd19};
      4'd10: r = '{5'd20, 5'd7, 4'd3, LED_YELLOW_BLINK, SRC_WARN, 2'd2, 5'd13, 5'd20};
      4'd11: r = '{5'd13, 5'd7, 4'd4, LED_YELLOW_BLINK, SRC_WARN, 2'd2, 5'd13, 5'd13};
      4'd12: r = '{5'd22, 5'd8, 4'd9, LED_RED_BLINK, SRC_VOLT, 2'd0, 5'd8, 5'd22};
      default: r = '{5'd21, 5'd8, 4'd10, LED_RED_BLINK, SRC_VOLT, 2'd1, 5'd8, 5'd21};
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/channel_mode_controller.sv =====
// Top level of the channel mode controller
// One item is one tick for one channel; each item in range yields one result item.
// Takes one item per cycle while the output side is not stalled: a register stage holds the
// accepted item, the per-channel mode and classifier state are read in that stage and updated
// as the item leaves it, and the result item lands in an output register behind the stage.
// Items for channels at or above CHANNELS are dropped without a result.
`timescale 1ns / 1ps
`default_nettype none
module channel_mode_controller
  import cmc_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [15:0] long_q;
  logic [7:0]  code_low_q, code_mid_q, code_high_q;
  logic [4:0]  mode_q [CHANNELS];
  logic        armed_q [CHANNELS];
  logic [15:0] count_q [CHANNELS];

  logic      s1_valid_q;
  in_item_t  s1_q;
  logic      s1_ready;
  logic      out_valid_q;
  out_item_t out_q;

  logic [IdxW-1:0] idx;
  logic [4:0]  m, nm;
  logic        cur_armed, new_armed;
  logic [15:0] cur_count, new_count;
  event_e      ev;
  logic        consult;
  out_item_t   res;
  detail_row_t row;
  logic [3:0]  flags, full;
  logic [7:0]  code;
  logic        volt_bad, fault_bad, warn3_bad;

  assign cfg_ready_o = 1'b1;
  assign s1_ready    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s1_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign idx       = s1_q.channel[IdxW-1:0];
  assign m         = mode_q[idx];
  assign cur_armed = armed_q[idx];
  assign cur_count = count_q[idx];

  cmc_classifier u_cls (
    .limit_i  (long_q),
    .pressed_i(s1_q.key_pressed),
    .armed_i  (cur_armed),
    .count_i  (cur_count),
    .armed_o  (new_armed),
    .count_o  (new_count),
    .event_o  (ev)
  );

  always_comb begin
    volt_bad  = s1_q.volt_ok != 2'b11;
    fault_bad = s1_q.fault_ok != 4'hF;
    warn3_bad = s1_q.warn_ok[2:0] != 3'b111;
    row   = detail_row(4'(m - M_WARN_DET));
    flags = (row.src == SRC_WARN) ? s1_q.warn_ok :
            (row.src == SRC_FAULT) ? s1_q.fault_ok : {2'b00, s1_q.volt_ok};
    full  = (row.src == SRC_VOLT) ? 4'h3 : 4'hF;
    code  = (m == M_SEL_LOW) ? code_low_q : (m == M_SEL_MID) ? code_mid_q : code_high_q;
    nm = m;
    consult = 1'b0;
    res = '0;
    res.out_channel = s1_q.channel;
    res.led_code = LED_KEEP;
    if (m == M_OFF || m == M_READY) begin
      res.ack_open_circuit = 1'b1;
      consult = 1'b1;
      if (m == M_OFF) begin
        if (ev == EV_SHORT) nm = M_READY;
        else if (ev == EV_LONG) nm = M_SEL_LOW;
        res.led_code = LED_BLUE;
      end else begin
        if (ev == EV_SHORT) nm = M_MON;
        res.led_code = LED_GREEN_PAT;
      end
    end else if (m == M_MON) begin
      consult = 1'b1;
      nm = (ev == EV_LONG) ? M_OFF : M_MON;
      if (volt_bad) nm = M_VOLT;
      else if (fault_bad) begin nm = M_FAULT; res.led_code = LED_RED; end
      else if (warn3_bad) begin nm = M_WARN; res.led_code = LED_YELLOW; end
      else res.led_code = LED_GREEN;
    end else if (m >= M_SEL_LOW && m <= M_SEL_HIGH) begin
      res.led_code = LED_BLUE_PAT;
      consult = 1'b1;
      if (ev == EV_SHORT) nm = (m == M_SEL_HIGH) ? M_SEL_LOW : m + 5'd1;
      else if (ev == EV_LONG) begin
        res.setpoint_write = 1'b1;
        res.setpoint_word = {code, code};
        res.setpoint_shifted = {1'b0, code, 7'd0} | {9'd0, code[7:1]};
        nm = M_MON;
      end
    end else if (m == M_WARN || m == M_FAULT) begin
      res.led_code = (m == M_WARN) ? LED_YELLOW : LED_RED;
      if (m == M_FAULT && !fault_bad) nm = M_MON;
      else if (volt_bad) nm = M_VOLT;
      else if (m == M_WARN && fault_bad) begin nm = M_FAULT; res.led_code = LED_RED; end
      else if (m == M_WARN && !warn3_bad) nm = M_MON;
      else begin
        consult = 1'b1;
        if (ev == EV_SHORT) nm = (m == M_WARN) ? M_WARN_DET : M_FAULT_DET;
        else if (ev == EV_LONG) begin res.ack_alarms = 1'b1; nm = M_OFF; end
      end
    end else if (m == M_VOLT) begin
      res.led_code = LED_RED_YELLOW;
      if (!volt_bad) nm = M_MON;
      else begin
        consult = 1'b1;
        if (ev == EV_SHORT) nm = M_VOLT_DET;
        else if (ev == EV_LONG) begin res.ack_alarms = 1'b1; nm = M_OFF; end
      end
    end else if (m >= M_WARN_DET && m <= M_LAST_DET) begin
      consult = 1'b1;
      res.detail_code = row.detail;
      res.led_code = row.led;
      if (ev == EV_SHORT) nm = row.on_short;
      else if (ev == EV_LONG) nm = row.on_long;
      if (flags == full) nm = row.all_next;
      else if (flags[row.bit_sel]) nm = row.flag_next;
    end else begin
      nm = M_OFF;
    end
    res.mode = nm;
  end

  logic s1_go, in_range;
  assign s1_go    = s1_valid_q && s1_ready;
  assign in_range = 32'(in_data_i.channel) < CHANNELS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q <= LongPressReset;
      code_low_q <= '0;
      code_mid_q <= '0;
      code_high_q <= '0;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        mode_q[i] <= '0;
        armed_q[i] <= 1'b0;
        count_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_LONG: long_q <= cfg_data_i;
          REG_LOW:  code_low_q <= cfg_data_i[7:0];
          REG_MID:  code_mid_q <= cfg_data_i[7:0];
          REG_HIGH: code_high_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_ready_o) s1_valid_q <= in_valid_i && in_range;
      if (s1_ready) out_valid_q <= s1_valid_q;
      if (s1_go) begin
        mode_q[idx] <= nm;
        if (consult) begin
          armed_q[idx] <= new_armed;
          count_q[idx] <= new_count;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) s1_q <= in_data_i;
    if (s1_go) out_q <= res;
  end
endmodule
`default_nettype wire

// ===== rtl/core/cmc_classifier.sv =====
// Press classifier: next armed flag, counter and event for one channel
`timescale 1ns / 1ps
`default_nettype none
module cmc_classifier
  import cmc_pkg::*;
(
  input  logic [15:0] limit_i,
  input  logic        pressed_i,
  input  logic        armed_i,
  input  logic [15:0] count_i,
  output logic        armed_o,
  output logic [15:0] count_o,
  output event_e      event_o
);
  logic [15:0] inc;

  always_comb begin
    inc = (count_i == 16'hFFFF) ? count_i : count_i + 16'd1;
    armed_o = armed_i;
    count_o = count_i;
    event_o = EV_NONE;
    if (!pressed_i) begin
      armed_o = 1'b1;
      if (count_i <= (limit_i >> 4)) begin
        count_o = '0;
      end else if (count_i <= limit_i) begin
        count_o = '0;
        event_o = EV_SHORT;
      end
    end else if (armed_i) begin
      count_o = inc;
      if (inc >= limit_i) begin
        count_o = '0;
        armed_o = 1'b0;
        event_o = EV_LONG;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/cmc_checker.sv =====
// Port-level checker for the channel mode controller, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "channel_mode_controller_assert.svh"
module cmc_checker
  import cmc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);
  `CMC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `CMC_ASSERT_IMP(a_no_sp_idle, clk_i, rst_ni, out_valid_o && !out_data_o.setpoint_write, out_data_o.setpoint_word == 16'd0)
  `CMC_ASSERT_IMP(a_ack_excl, clk_i, rst_ni, out_valid_o, !(out_data_o.ack_alarms && out_data_o.ack_open_circuit))
  `CMC_ASSERT_IMP(a_sp_mode, clk_i, rst_ni, out_valid_o && out_data_o.setpoint_write, out_data_o.mode == M_MON)
  `CMC_ASSERT_IMP(a_in_stall, clk_i, rst_ni, in_valid_i && !in_ready_o, out_valid_o && !out_ready_i)
endmodule

bind channel_mode_controller cmc_checker u_cmc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

// ===== bench/channel_mode_controller_checker.sv =====
// Checker for the channel mode controller: per-channel mode prediction and result compare
`timescale 1ns / 1ps
`default_nettype none
module channel_mode_controller_checker
  import cmc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int        errors_o,
  output int        pending_o
);
  localparam int NumCh = 10;

  typedef struct packed {
    logic [4:0] on_short;
    logic [4:0] on_long;
    logic [3:0] detail;
    logic [3:0] led;
    src_e       src;
    logic [1:0] flag_bit;
    logic [4:0] all_next;
    logic [4:0] flag_next;
  } det_step_t;

  logic [15:0] long_ticks;
  logic [7:0]  code_low, code_mid, code_high;
  logic [4:0]  chan_mode [NumCh];
  logic        armed [NumCh];
  logic [15:0] hold_cnt [NumCh];
  out_item_t   expected_q [$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  function automatic det_step_t det_step(input logic [4:0] m);
    case (m)
      5'd9:    return '{5'd10, 5'd6, 4'd1, LED_YELLOW_BLINK, SRC_WARN, 2'd0, 5'd6, 5'd10};
      5'd10:   return '{5'd11, 5'd6, 4'd2, LED_YELLOW_BLINK, SRC_WARN, 2'd1, 5'd6, 5'd11};
      5'd11:   return '{5'd12, 5'd6, 4'd3, LED_YELLOW_BLINK, SRC_WARN, 2'd2, 5'd6, 5'd12};
      5'd12:   return '{5'd9,  5'd6, 4'd4, LED_YELLOW_BLINK, SRC_WARN, 2'd3, 5'd6, 5'd9};
      5'd13:   return '{5'd14, 5'd7, 4'd5, LED_RED_BLINK, SRC_FAULT, 2'd0, 5'd7, 5'd14};
      5'd14:   return '{5'd15, 5'd7, 4'd6, LED_RED_BLINK, SRC_FAULT, 2'd1, 5'd7, 5'd15};
      5'd15:   return '{5'd16, 5'd7, 4'd7, LED_RED_BLINK, SRC_FAULT, 2'd2, 5'd7, 5'd16};
      5'd16:   return '{5'd17, 5'd7, 4'd8, LED_RED_BLINK, SRC_FAULT, 2'd3, 5'd7, 5'd17};
      5'd17:   return '{5'd18, 5'd7, 4'd1, LED_YELLOW_BLINK, SRC_WARN, 2'd0, 5'd13, 5'd18};
      5'd18:   return '{5'd19, 5'd7, 4'd2, LED_YELLOW_BLINK, SRC_WARN, 2'd1, 5'd13, 5'd19};
      5'd19:   return '{5'd20, 5'd7, 4'd3, LED_YELLOW_BLINK, SRC_WARN, 2'd2, 5'd13, 5'd20};
      5'd20:   return '{5'd13, 5'd7, 4'd4, LED_YELLOW_BLINK, SRC_WARN, 2'd2, 5'd13, 5'd13};
      5'd21:   return '{5'd22, 5'd8, 4'd9, LED_RED_BLINK, SRC_VOLT, 2'd0, 5'd8, 5'd22};
      default: return '{5'd21, 5'd8, 4'd10, LED_RED_BLINK, SRC_VOLT, 2'd1, 5'd8, 5'd21};
    endcase
  endfunction

  function automatic event_e classify_press(input int ch, input logic key);
    logic [15:0] c;
    if (!key) begin
      armed[ch] = 1'b1;
      if (hold_cnt[ch] <= (long_ticks >> 4)) begin
        hold_cnt[ch] = '0;
        return EV_NONE;
      end
      if (hold_cnt[ch] <= long_ticks) begin
        hold_cnt[ch] = '0;
        return EV_SHORT;
      end
      return EV_NONE;
    end
    if (armed[ch]) begin
      c = (hold_cnt[ch] == 16'hFFFF) ? 16'hFFFF : hold_cnt[ch] + 16'd1;
      hold_cnt[ch] = c;
      if (c >= long_ticks) begin
        hold_cnt[ch] = '0;
        armed[ch] = 1'b0;
        return EV_LONG;
      end
    end
    return EV_NONE;
  endfunction

  task automatic predict_mode(input in_item_t it);
    int        ch;
    logic [4:0] m, nm;
    logic [3:0] led, det, flags, full;
    logic [7:0] code;
    event_e    ev;
    det_step_t row;
    logic      vb, fb, wb;
    out_item_t r;
    ch = it.channel;
    if (ch >= NumCh) return;
    m = chan_mode[ch];
    nm = m;
    led = LED_KEEP;
    det = '0;
    r = '0;
    vb = it.volt_ok != 2'b11;
    fb = it.fault_ok != 4'hF;
    wb = it.warn_ok[2:0] != 3'b111;
    if (m == M_OFF || m == M_READY) begin
      r.ack_open_circuit = 1'b1;
      ev = classify_press(ch, it.key_pressed);
      if (m == M_OFF) begin
        if (ev == EV_SHORT) nm = M_READY;
        else if (ev == EV_LONG) nm = M_SEL_LOW;
        led = LED_BLUE;
      end else begin
        if (ev == EV_SHORT) nm = M_MON;
        led = LED_GREEN_PAT;
      end
    end else if (m == M_MON) begin
      ev = classify_press(ch, it.key_pressed);
      nm = (ev == EV_LONG) ? M_OFF : M_MON;
      if (vb) nm = M_VOLT;
      else if (fb) begin
        nm = M_FAULT;
        led = LED_RED;
      end else if (wb) begin
        nm = M_WARN;
        led = LED_YELLOW;
      end else led = LED_GREEN;
    end else if (m >= M_SEL_LOW && m <= M_SEL_HIGH) begin
      led = LED_BLUE_PAT;
      ev = classify_press(ch, it.key_pressed);
      if (ev == EV_SHORT) nm = (m == M_SEL_HIGH) ? M_SEL_LOW : m + 5'd1;
      else if (ev == EV_LONG) begin
        code = (m == M_SEL_LOW) ? code_low : (m == M_SEL_MID) ? code_mid : code_high;
        r.setpoint_write = 1'b1;
        r.setpoint_word = {code, code};
        r.setpoint_shifted = ({8'd0, code} >> 1) | ({8'd0, code} << 7);
        nm = M_MON;
      end
    end else if (m == M_WARN || m == M_FAULT) begin
      led = (m == M_WARN) ? LED_YELLOW : LED_RED;
      if (m == M_FAULT && !fb) nm = M_MON;
      else if (vb) nm = M_VOLT;
      else if (m == M_WARN && fb) begin
        nm = M_FAULT;
        led = LED_RED;
      end else if (m == M_WARN && !wb) nm = M_MON;
      else begin
        ev = classify_press(ch, it.key_pressed);
        if (ev == EV_SHORT) nm = (m == M_WARN) ? M_WARN_DET : M_FAULT_DET;
        else if (ev == EV_LONG) begin
          r.ack_alarms = 1'b1;
          nm = M_OFF;
        end
      end
    end else if (m == M_VOLT) begin
      led = LED_RED_YELLOW;
      if (!vb) nm = M_MON;
      else begin
        ev = classify_press(ch, it.key_pressed);
        if (ev == EV_SHORT) nm = M_VOLT_DET;
        else if (ev == EV_LONG) begin
          r.ack_alarms = 1'b1;
          nm = M_OFF;
        end
      end
    end else if (m >= M_WARN_DET && m <= M_LAST_DET) begin
      row = det_step(m);
      flags = (row.src == SRC_WARN) ? it.warn_ok :
              (row.src == SRC_FAULT) ? it.fault_ok : {2'b00, it.volt_ok};
      full = (row.src == SRC_VOLT) ? 4'h3 : 4'hF;
      det = row.detail;
      led = row.led;
      ev = classify_press(ch, it.key_pressed);
      if (ev == EV_SHORT) nm = row.on_short;
      else if (ev == EV_LONG) nm = row.on_long;
      if (flags == full) nm = row.all_next;
      else if (flags[row.flag_bit]) nm = row.flag_next;
    end else nm = M_OFF;
    chan_mode[ch] = nm;
    r.out_channel = it.channel;
    r.mode = nm;
    r.detail_code = det;
    r.led_code = led;
    expected_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      long_ticks <= LongPressReset;
      code_low <= '0;
      code_mid <= '0;
      code_high <= '0;
      for (int i = 0; i < NumCh; i++) begin
        chan_mode[i] = M_OFF;
        armed[i] = 1'b0;
        hold_cnt[i] = '0;
      end
      expected_q.delete();
      errors = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result item with no expectation, channel %0d", out_data_i.out_channel);
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("out_channel", e.out_channel, out_data_i.out_channel);
          check_field("mode", e.mode, out_data_i.mode);
          check_field("detail_code", e.detail_code, out_data_i.detail_code);
          check_field("led_code", e.led_code, out_data_i.led_code);
          check_field("setpoint_write", e.setpoint_write, out_data_i.setpoint_write);
          check_field("setpoint_word", e.setpoint_word, out_data_i.setpoint_word);
          check_field("setpoint_shifted", e.setpoint_shifted, out_data_i.setpoint_shifted);
          check_field("ack_open_circuit", e.ack_open_circuit, out_data_i.ack_open_circuit);
          check_field("ack_alarms", e.ack_alarms, out_data_i.ack_alarms);
        end
      end
      if (in_valid_i && in_ready_i) predict_mode(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_LONG: long_ticks <= cfg_data_i;
          REG_LOW:  code_low <= cfg_data_i[7:0];
          REG_MID:  code_mid <= cfg_data_i[7:0];
          default:  code_high <= cfg_data_i[7:0];
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== bench/channel_mode_controller_tb.sv =====
// Testbench top for the channel mode controller: stimulus, config phases and verdict
`timescale 1ns / 1ps
`default_nettype none
module channel_mode_controller_tb;
  import cmc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_LONG;
  logic [15:0] cfg_data_i = '0;
  int          errors;
  int          pending;
  int          idle_in;
  int          idle_out;
  int          press_len;
  int          hold_left [10];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  channel_mode_controller DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o, .out_ready_i,
    .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  channel_mode_controller_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) out_ready_i <= $urandom_range(99) >= idle_out;

  task automatic send_item(input logic [3:0] ch, input logic key, input logic [3:0] f,
                           input logic [3:0] w, input logic [1:0] v);
    while ($urandom_range(99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{ch, key, f, w, v};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic press(input logic [3:0] ch, input int n, input logic [1:0] v);
    repeat (n) send_item(ch, 1'b1, 4'hF, 4'hF, v);
    send_item(ch, 1'b0, 4'hF, 4'hF, v);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [15:0] lim, input logic [7:0] lo,
                            input logic [7:0] mid, input logic [7:0] hi);
    logic [15:0] vals [4];
    vals = '{lim, {8'd0, lo}, {8'd0, mid}, {8'd0, hi}};
    press_len = lim;
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[1:0];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_items(input int n);
    logic [3:0] ch;
    logic       key;
    int         lim;
    int         shrt;
    for (int k = 0; k < n; k++) begin
      lim = (press_len > 40) ? 40 : press_len;
      shrt = press_len >> 4;
      ch = ($urandom_range(19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(9));
      key = 1'b0;
      if (ch < 10) begin
        if (hold_left[ch] > 0) begin
          key = 1'b1;
          hold_left[ch]--;
        end else if ($urandom_range(9) < 6) begin
          case ($urandom_range(3))
            0: hold_left[ch] = $urandom_range(shrt + 1, lim);
            1: hold_left[ch] = $urandom_range(lim, lim + 3);
            2: hold_left[ch] = $urandom_range(0, shrt);
            default: hold_left[ch] = $urandom_range(0, lim + 8);
          endcase
        end
      end else key = $urandom_range(1);
      send_item(ch, key,
                ($urandom_range(3) == 0) ? 4'($urandom) : 4'hF,
                ($urandom_range(3) == 0) ? 4'($urandom) : 4'hF,
                ($urandom_range(5) == 0) ? 2'($urandom) : 2'b11);
    end
  endtask

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    for (int i = 0; i < 10; i++) hold_left[i] = 0;
    idle_in = 7;
    idle_out = 75;
    press_len = 4000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_regs(16'd16, 8'h00, 8'hFF, 8'hA5);
    // off -> ready -> monitoring on channel 0
    press(4'd0, 3, 2'b11);
    press(4'd0, 3, 2'b11);
    send_item(4'd0, 1'b0, 4'hF, 4'hF, 2'b01);
    press(4'd0, 3, 2'b01);
    send_item(4'd0, 1'b0, 4'hF, 4'hF, 2'b11);
    send_item(4'd9, 1'b1, 4'h0, 4'h0, 2'b00);
    send_item(4'd10, 1'b1, 4'h0, 4'h0, 2'b00);
    send_item(4'd15, 1'b0, 4'hF, 4'hF, 2'b11);
    random_items(200);
    drain();
    idle_in = 75;
    idle_out = 7;
    write_regs(16'd1, 8'h5A, 8'h81, 8'h7F);
    random_items(100);
    drain();
    write_regs(16'hFFFF, 8'hFF, 8'h00, 8'h01);
    random_items(50);
    drain();
    idle_in = 0;
    idle_out = 0;
    write_regs(16'd24, 8'($urandom), 8'($urandom), 8'($urandom));
    random_items(250);
    drain();
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
